[rtl/gpr16_cpu_core_macros.svh]
// Assertion macros shared by the gpr16 CPU core RTL.
// No dependencies; the checks compile away when SYNTH is defined.
`ifndef GPR16_CPU_CORE_MACROS_SVH
`define GPR16_CPU_CORE_MACROS_SVH
`ifndef SYNTH
// Checked while reset is low.
`define GPR16_CHECK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define GPR16_CHECK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GPR16_CHECK(lbl, clk, rst, prop, msg)
`define GPR16_CHECK_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/gpr16_pkg.sv]
// Shared types, codes and helpers for the gpr16 CPU core.
// No dependencies; used by the ALU and the top level of the block.
package gpr16_pkg;

  localparam int MEM_WORDS_DEF = 4096;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  localparam logic [3:0] OP_HALT  = 4'd0;
  localparam logic [3:0] OP_MOVI  = 4'd1;
  localparam logic [3:0] OP_MOV   = 4'd2;
  localparam logic [3:0] OP_LOAD  = 4'd3;
  localparam logic [3:0] OP_STORE = 4'd4;
  localparam logic [3:0] OP_ADD   = 4'd5;
  localparam logic [3:0] OP_SUB   = 4'd6;
  localparam logic [3:0] OP_AND   = 4'd7;
  localparam logic [3:0] OP_OR    = 4'd8;
  localparam logic [3:0] OP_XOR   = 4'd9;
  localparam logic [3:0] OP_NOT   = 4'd10;
  localparam logic [3:0] OP_SHL   = 4'd11;
  localparam logic [3:0] OP_SHR   = 4'd12;
  localparam logic [3:0] OP_JMP   = 4'd13;
  localparam logic [3:0] OP_JZ    = 4'd14;
  localparam logic [3:0] OP_NOP   = 4'd15;

  typedef struct packed {
    logic n;
    logic c;
    logic z;
  } flags_t;

  typedef struct packed {
    logic [15:0] result;
    logic        reg_we;
    logic        flag_we;
    flags_t      flags;
    logic        halt;
    logic        jump;
    logic        store;
    logic        load;
  } alu_out_t;

  function automatic flags_t zn_flags(logic [15:0] r, logic carry);
    flags_t f;
    f.z = (r == 16'h0000);
    f.n = r[15];
    f.c = carry;
    return f;
  endfunction

endpackage

[rtl/gpr16_cmd_if.sv]
// Request channel of the gpr16 CPU core: kind, address and data.
// No dependencies.
interface gpr16_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [15:0] data;

  modport source (output valid, kind, address, data, input ready);
  modport sink (input valid, kind, address, data, output ready);
endinterface

[rtl/gpr16_res_if.sv]
// Result channel of the gpr16 CPU core: read word, PC, flags and status.
// No dependencies.
interface gpr16_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [15:0] pc;
  logic        zero;
  logic        carry;
  logic        negative;
  logic        halted;
  logic        stepped;

  modport source (output valid, read_data, pc, zero, carry, negative,
                  halted, stepped, input ready);
  modport sink (input valid, read_data, pc, zero, carry, negative,
                halted, stepped, output ready);
endinterface

[rtl/gpr16_word_mem.sv]
// Word memory of the gpr16 core: one port, registered read, clearing pass after reset.
// Depends on nothing outside this file.
module gpr16_word_mem #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic                         rd_en,
  input  logic [$clog2(MEM_WORDS)-1:0] addr,
  input  logic [15:0]                  wdata,
  output logic [15:0]                  rdata,
  output logic                         clearing
);
  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [AW-1:0] LAST = AW'(MEM_WORDS - 1);

  logic [15:0]   mem [MEM_WORDS];
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= 16'h0000;
    end else if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end
endmodule

[rtl/gpr16_reg_file.sv]
// Eight-entry register file of the gpr16 core: two registered reads, one write.
// Entries never written since reset read as zero through per-entry valid bits.
module gpr16_reg_file (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [2:0]  ra,
  input  logic [2:0]  rb,
  output logic [15:0] a_data,
  output logic [15:0] b_data,
  input  logic        we,
  input  logic [2:0]  waddr,
  input  logic [15:0] wdata
);
  logic [15:0] regs [8];
  logic [7:0]  valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      regs[waddr] <= wdata;
    end
    if (rd_en) begin
      a_data <= valid[ra] ? regs[ra] : 16'h0000;
      b_data <= valid[rb] ? regs[rb] : 16'h0000;
    end
  end
endmodule

[rtl/gpr16_alu.sv]
// Instruction decode and ALU of the gpr16 core.
// Depends on gpr16_pkg for opcodes, flag and result types.
module gpr16_alu
  import gpr16_pkg::*;
(
  input  logic [15:0] instr,
  input  logic [15:0] a,
  input  logic [15:0] b,
  input  flags_t      flags,
  output alu_out_t    res
);
  logic [3:0]  op;
  logic [15:0] imm;
  logic [16:0] sum;

  assign op  = instr[15:12];
  assign imm = {7'b0, instr[8:0]};
  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    res = '0;
    case (op)
      OP_HALT: res.halt = 1'b1;
      OP_MOVI: begin
        res.result = imm;
        res.reg_we = 1'b1;
      end
      OP_MOV: begin
        res.result = b;
        res.reg_we = 1'b1;
      end
      OP_LOAD:  res.load = 1'b1;
      OP_STORE: res.store = 1'b1;
      OP_ADD: begin
        res.result = sum[15:0];
        res.reg_we = 1'b1;
      end
      OP_SUB: begin
        res.result = a - b;
        res.reg_we = 1'b1;
      end
      OP_AND: begin
        res.result = a & b;
        res.reg_we = 1'b1;
      end
      OP_OR: begin
        res.result = a | b;
        res.reg_we = 1'b1;
      end
      OP_XOR: begin
        res.result = a ^ b;
        res.reg_we = 1'b1;
      end
      OP_NOT: begin
        res.result = ~b;
        res.reg_we = 1'b1;
      end
      OP_SHL: begin
        res.result = {a[14:0], 1'b0};
        res.reg_we = 1'b1;
      end
      OP_SHR: begin
        res.result = {1'b0, a[15:1]};
        res.reg_we = 1'b1;
      end
      OP_JMP: res.jump = 1'b1;
      OP_JZ:  res.jump = flags.z;
      default: ;
    endcase

    // Every register-writing op also rewrites the flags.
    res.flag_we = res.reg_we;
    case (op)
      OP_ADD:  res.flags = zn_flags(res.result, sum[16]);
      OP_SUB:  res.flags = zn_flags(res.result, a >= b);
      OP_SHL:  res.flags = zn_flags(res.result, a[15]);
      OP_SHR:  res.flags = zn_flags(res.result, a[0]);
      default: res.flags = zn_flags(res.result, 1'b0);
    endcase
  end
endmodule

[rtl/gpr16_cpu_core.sv]
// Top level of the gpr16 CPU core: sequencer, PC, flags and result register.
// Depends on gpr16_pkg, both channel interfaces, the memories, the ALU and the macros.
//
// Usage: requests arrive on cmd (valid/ready); kind selects a memory word
// write, a memory word read, or one instruction step. Every request yields
// exactly one result on the result channel, carrying the word read (or the
// fetched instruction), the PC, the Z/C/N flags, the halt bit and a stepped
// bit that is set when an instruction ran and the core is still running.
// Requests are handled one at a time. A write, the unused kind or a step while
// halted goes from IDLE straight to DONE; a read passes through READ, an
// instruction step through FETCH and EXEC, and a LOAD step also through LOAD;
// the chain follows the registered word memory read (fetch, then data access)
// with the registered register-file read between them. The result register lets the
// next request be accepted while a finished result still waits; a request that
// completes while that register is still full waits in its final state
// until the receiver takes the older result.
// After reset all registers, flags and the halt bit are zero, and the word
// memory is swept to zero, one word per cycle, and cmd.ready stays low
// during that sweep.
`include "gpr16_cpu_core_macros.svh"
module gpr16_cpu_core
  import gpr16_pkg::*;
#(
  parameter int MEM_WORDS = MEM_WORDS_DEF
) (
  input logic         clk,
  input logic         rst,
  gpr16_cmd_if.sink   cmd,
  gpr16_res_if.source result
);
  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  function automatic logic in_rng(logic [15:0] a);
    return {1'b0, a} < MEM_LIMIT;
  endfunction

  // Architectural state outside the two memories.
  logic [2:0]  state;
  logic [15:0] pc;
  flags_t      flags;
  logic        halt;

  // Per-request working registers.
  logic [15:0] instr;
  logic [15:0] rdata_hold;
  logic        stepped_q;
  logic        rd_ok;

  // Result register.
  logic        out_valid;
  logic [15:0] out_read_data;
  logic [15:0] out_pc;
  flags_t      out_flags;
  logic        out_halted;
  logic        out_stepped;

  logic        accept;
  logic        mem_we;
  logic        mem_re;
  logic [15:0] mem_addr16;
  logic [15:0] mem_wdata;
  logic [15:0] mem_rdata;
  logic [15:0] mem_word;
  logic        mem_clearing;

  logic        rf_we;
  logic [15:0] rf_wdata;
  logic [15:0] ra_data;
  logic [15:0] rb_data;
  alu_out_t    alu;
  logic        out_free;

  assign cmd.ready = (state == S_IDLE) && !mem_clearing;
  assign accept    = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || result.ready;

  // A read whose address fell outside the memory returns zero.
  assign mem_word = rd_ok ? mem_rdata : 16'h0000;

  // Memory port: the request itself, the instruction fetch, or the data access.
  always_comb begin
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr16 = cmd.address;
    mem_wdata  = cmd.data;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd.kind)
            KIND_WRITE: mem_we = in_rng(cmd.address);
            KIND_READ:  mem_re = 1'b1;
            KIND_STEP: begin
              mem_re     = !halt;
              mem_addr16 = pc;
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        mem_addr16 = rb_data;
        mem_wdata  = ra_data;
        mem_we     = alu.store && in_rng(rb_data);
        mem_re     = alu.load;
      end
      default: ;
    endcase
  end

  // Register file write: ALU result in EXEC, loaded word in LOAD.
  always_comb begin
    rf_we    = 1'b0;
    rf_wdata = alu.result;
    case (state)
      S_EXEC: rf_we = alu.reg_we;
      S_LOAD: begin
        rf_we    = 1'b1;
        rf_wdata = mem_word;
      end
      default: ;
    endcase
  end

  gpr16_word_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (mem_we),
    .rd_en    (mem_re),
    .addr     (mem_addr16[AW-1:0]),
    .wdata    (mem_wdata),
    .rdata    (mem_rdata),
    .clearing (mem_clearing)
  );

  // Register operands are read as the fetched word comes out of memory.
  gpr16_reg_file u_rf (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (state == S_FETCH),
    .ra     (mem_word[11:9]),
    .rb     (mem_word[8:6]),
    .a_data (ra_data),
    .b_data (rb_data),
    .we     (rf_we),
    .waddr  (instr[11:9]),
    .wdata  (rf_wdata)
  );

  gpr16_alu u_alu (
    .instr (instr),
    .a     (ra_data),
    .b     (rb_data),
    .flags (flags),
    .res   (alu)
  );

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_ok <= in_rng(mem_addr16);
    end
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= 16'h0000;
      flags <= '0;
      halt  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            rdata_hold <= 16'h0000;
            stepped_q  <= 1'b0;
            case (cmd.kind)
              KIND_READ: state <= S_READ;
              KIND_STEP: state <= halt ? S_DONE : S_FETCH;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          rdata_hold <= mem_word;
          state      <= S_DONE;
        end
        S_FETCH: begin
          instr      <= mem_word;
          rdata_hold <= mem_word;
          pc         <= pc + 16'd1;
          state      <= S_EXEC;
        end
        S_EXEC: begin
          if (alu.flag_we) begin
            flags <= alu.flags;
          end
          if (alu.halt) begin
            halt <= 1'b1;
          end
          if (alu.jump) begin
            pc <= rb_data;
          end
          stepped_q <= !alu.halt;
          state     <= alu.load ? S_LOAD : S_DONE;
        end
        S_LOAD: begin
          flags <= zn_flags(mem_word, 1'b0);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register: filled from the final state, drained by the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_read_data <= rdata_hold;
      out_pc        <= pc;
      out_flags     <= flags;
      out_halted    <= halt;
      out_stepped   <= stepped_q;
    end
  end

  assign result.valid     = out_valid;
  assign result.read_data = out_read_data;
  assign result.pc        = out_pc;
  assign result.zero      = out_flags.z;
  assign result.carry     = out_flags.c;
  assign result.negative  = out_flags.n;
  assign result.halted    = out_halted;
  assign result.stepped   = out_stepped;

  `GPR16_CHECK(a_no_req_while_clearing, clk, rst, cmd.ready |-> !mem_clearing, "request ready during memory sweep")
  `GPR16_CHECK(a_halt_sticky, clk, rst, halt |=> halt, "halt bit dropped without reset")
  `GPR16_CHECK(a_halted_step_keeps_pc, clk, rst, (accept && cmd.kind == KIND_STEP && halt) |=> (pc == $past(pc)), "step while halted moved the PC")
  `GPR16_CHECK(a_stepped_not_halted, clk, rst, (out_valid && out_stepped) |-> !out_halted, "stepped result reports halted core")
  `GPR16_CHECK_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE && !out_valid), "reset did not clear the sequencer")
endmodule
